[design/cwpc_pkg.sv]
// Shared constants, types and reset values of the convex window polygon clipper.
package cwpc_pkg;

  // Coordinate format: signed fixed point, 8 fraction bits.
  localparam int COORD_BITS = 24;
  // Number of window edges, one clipping cell each (3 or 4).
  localparam int CLIP_EDGES = 4;
  localparam int STAGES = (CLIP_EDGES < 3) ? 3 : ((CLIP_EDGES > 4) ? 4 : CLIP_EDGES);

  // Configuration register file.
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;

  // Stream word width: two coordinates padded to whole bytes.
  localparam int DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

  // Cross product and intersection arithmetic widths.
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = 2 * COORD_BITS + 4;
  localparam int REM_W     = CROSS_W + 2;
  localparam int QUO_W     = COORD_BITS + 2;
  localparam int DIV_STEPS = DIFF_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CROSS_W-1:0]    cross_t;
  typedef logic signed [QUO_W:0]        fix_t;

  // One word travelling along the chain of cells: a vertex, a ring close, or both.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   hv;
    logic   cl;
  } tok_t;

  // Reset values of the window corners: x0, y0, x1, y1, x2, y2, x3, y3.
  localparam coord_t CLIP_RESET [NUM_REGS] = '{
    coord_t'(25600),  coord_t'(51200),  coord_t'(179200), coord_t'(51200),
    coord_t'(179200), coord_t'(92160),  coord_t'(25600),  coord_t'(92160)
  };

endpackage

[design/cwpc_muldiv.sv]
// Iterative multiply-divide unit: floor(a * m / d) with a remainder flag, one bit of a per cycle.
module cwpc_muldiv (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cwpc_pkg::DIFF_W-1:0]   mul_a,
  input  logic [cwpc_pkg::CROSS_W-1:0]  mcand,
  input  logic [cwpc_pkg::CROSS_W-1:0]  dvsr,
  output logic                          busy,
  output logic [cwpc_pkg::QUO_W-1:0]    quo,
  output logic                          rem_nz
);

  logic [cwpc_pkg::DIFF_W-1:0]  a_sh;
  logic [cwpc_pkg::CROSS_W-1:0] m;
  logic [cwpc_pkg::CROSS_W-1:0] dv;
  logic [cwpc_pkg::REM_W-1:0]   r;
  logic [cwpc_pkg::CNT_W-1:0]   cnt;

  logic [cwpc_pkg::REM_W-1:0] r2;
  logic [cwpc_pkg::REM_W-1:0] d1;
  logic [cwpc_pkg::REM_W-1:0] d2;
  logic [cwpc_pkg::REM_W-1:0] r_next;
  logic [1:0]                 inc;

  // One step: bring in the next multiplier bit, then take out the divisor up to twice.
  always_comb begin
    r2 = {r[cwpc_pkg::REM_W-2:0], 1'b0}
         + (a_sh[cwpc_pkg::DIFF_W-1] ? cwpc_pkg::REM_W'(m) : '0);
    d1 = cwpc_pkg::REM_W'(dv);
    d2 = {d1[cwpc_pkg::REM_W-2:0], 1'b0};
    if (r2 >= d2) begin
      r_next = r2 - d2;
      inc    = 2'd2;
    end else if (r2 >= d1) begin
      r_next = r2 - d1;
      inc    = 2'd1;
    end else begin
      r_next = r2;
      inc    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= cwpc_pkg::CNT_W'(cwpc_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == cwpc_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= mul_a;
      m    <= mcand;
      dv   <= dvsr;
      r    <= '0;
      quo  <= '0;
    end else if (busy) begin
      a_sh <= {a_sh[cwpc_pkg::DIFF_W-2:0], 1'b0};
      r    <= r_next;
      quo  <= {quo[cwpc_pkg::QUO_W-2:0], 1'b0} + cwpc_pkg::QUO_W'(inc);
    end
  end

  assign rem_nz = |r;

endmodule

[design/cwpc_cell.sv]
// One clipping cell: clips the vertex ring it receives against a single window edge.
module cwpc_cell (
  input  logic             clk,
  input  logic             rst,
  input  cwpc_pkg::coord_t ax,
  input  cwpc_pkg::coord_t ay,
  input  cwpc_pkg::coord_t bx,
  input  cwpc_pkg::coord_t by,
  input  logic             in_valid,
  output logic             in_ready,
  input  cwpc_pkg::tok_t   in_tok,
  output logic             out_valid,
  input  logic             out_ready,
  output cwpc_pkg::tok_t   out_tok
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CQ    = 4'd1;
  localparam logic [3:0] S_CP    = 4'd2;
  localparam logic [3:0] S_EDGE  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_FIX   = 4'd5;
  localparam logic [3:0] S_EMITQ = 4'd6;
  localparam logic [3:0] S_C0    = 4'd7;
  localparam logic [3:0] S_CTOK  = 4'd8;

  logic [3:0] state;

  // Working edge P->Q and the cell's ring state.
  cwpc_pkg::coord_t qx, qy, px, py;
  cwpc_pkg::coord_t firstx, firsty, prevx, prevy;
  cwpc_pkg::cross_t cq, cp;
  logic             qin, pin, tok_cl, closing, has, prev_in;

  // Cross product unit.
  cwpc_pkg::coord_t cx, cy;
  cwpc_pkg::diff_t  ex, ey, dpx, dpy;
  cwpc_pkg::prod_t  pa, pb;
  cwpc_pkg::cross_t cross_v;

  // Intersection support.
  cwpc_pkg::cross_t              det;
  cwpc_pkg::diff_t               dqx, dqy;
  logic [cwpc_pkg::DIFF_W-1:0]   adx, ady;
  logic [cwpc_pkg::CROSS_W-1:0]  cpm, detm;
  logic                          div_start, busy_x, busy_y, rnz_x, rnz_y;
  logic [cwpc_pkg::QUO_W-1:0]    quo_x, quo_y;
  cwpc_pkg::coord_t              ix, iy;
  logic                          slot_free;
  logic                          load;

  // Truncate P + d * cP / det toward zero, from the magnitude quotient.
  function automatic cwpc_pkg::coord_t cut(input cwpc_pkg::coord_t pc,
                                           input logic dneg,
                                           input logic [cwpc_pkg::QUO_W-1:0] q,
                                           input logic rnz,
                                           input logic sgn_cp,
                                           input logic sgn_det);
    cwpc_pkg::fix_t fl;
    cwpc_pkg::fix_t base;
    logic           neg;
    neg = dneg ^ sgn_cp ^ sgn_det;
    fl = cwpc_pkg::fix_t'({1'b0, q});
    if (neg) begin
      fl = -fl - cwpc_pkg::fix_t'({1'b0, rnz});
    end
    base = cwpc_pkg::fix_t'(pc) + fl;
    if (rnz && base[cwpc_pkg::QUO_W]) begin
      base = base + cwpc_pkg::fix_t'(1);
    end
    return base[cwpc_pkg::COORD_BITS-1:0];
  endfunction

  // Point under test for the cross product.
  always_comb begin
    case (state)
      S_C0: begin
        cx = firstx;
        cy = firsty;
      end
      S_CP: begin
        cx = prevx;
        cy = prevy;
      end
      default: begin
        cx = qx;
        cy = qy;
      end
    endcase
  end

  // Edge cross product (B-A) x (P-A).
  always_comb begin
    ex      = cwpc_pkg::diff_t'(bx) - cwpc_pkg::diff_t'(ax);
    ey      = cwpc_pkg::diff_t'(by) - cwpc_pkg::diff_t'(ay);
    dpx     = cwpc_pkg::diff_t'(cx) - cwpc_pkg::diff_t'(ax);
    dpy     = cwpc_pkg::diff_t'(cy) - cwpc_pkg::diff_t'(ay);
    pa      = cwpc_pkg::prod_t'(ex) * cwpc_pkg::prod_t'(dpy);
    pb      = cwpc_pkg::prod_t'(ey) * cwpc_pkg::prod_t'(dpx);
    cross_v = cwpc_pkg::cross_t'(pa) - cwpc_pkg::cross_t'(pb);
  end

  // Operand magnitudes for the intersection.
  always_comb begin
    det  = cp - cq;
    dqx  = cwpc_pkg::diff_t'(qx) - cwpc_pkg::diff_t'(px);
    dqy  = cwpc_pkg::diff_t'(qy) - cwpc_pkg::diff_t'(py);
    adx  = dqx[cwpc_pkg::DIFF_W-1] ? -dqx : dqx;
    ady  = dqy[cwpc_pkg::DIFF_W-1] ? -dqy : dqy;
    cpm  = cp[cwpc_pkg::CROSS_W-1] ? -cp : cp;
    detm = det[cwpc_pkg::CROSS_W-1] ? -det : det;
    ix   = cut(px, dqx[cwpc_pkg::DIFF_W-1], quo_x, rnz_x,
               cp[cwpc_pkg::CROSS_W-1], det[cwpc_pkg::CROSS_W-1]);
    iy   = cut(py, dqy[cwpc_pkg::DIFF_W-1], quo_y, rnz_y,
               cp[cwpc_pkg::CROSS_W-1], det[cwpc_pkg::CROSS_W-1]);
  end

  assign div_start = (state == S_EDGE) && (pin != qin) && (det != '0);
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // A word is loaded into the output register in this cycle.
  always_comb begin
    case (state)
      S_FIX:   load = slot_free;
      S_EMITQ: load = qin && slot_free;
      S_CTOK:  load = slot_free;
      default: load = 1'b0;
    endcase
  end

  cwpc_muldiv u_div_x (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .mul_a  (adx),
    .mcand  (cpm),
    .dvsr   (detm),
    .busy   (busy_x),
    .quo    (quo_x),
    .rem_nz (rnz_x)
  );

  cwpc_muldiv u_div_y (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .mul_a  (ady),
    .mcand  (cpm),
    .dvsr   (detm),
    .busy   (busy_y),
    .quo    (quo_y),
    .rem_nz (rnz_y)
  );

  // Sequencer: one push or ring close at a time, words handed on through the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      has       <= 1'b0;
      prev_in   <= 1'b0;
      closing   <= 1'b0;
      tok_cl    <= 1'b0;
      out_valid <= 1'b0;
      firstx    <= '0;
      firsty    <= '0;
      prevx     <= '0;
      prevy     <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            qx      <= in_tok.x;
            qy      <= in_tok.y;
            tok_cl  <= in_tok.cl;
            closing <= 1'b0;
            state   <= in_tok.hv ? S_CQ : S_C0;
          end
        end
        S_CQ: begin
          cq  <= cross_v;
          qin <= !cross_v[cwpc_pkg::CROSS_W-1];
          if (!has) begin
            firstx  <= qx;
            firsty  <= qy;
            prevx   <= qx;
            prevy   <= qy;
            prev_in <= !cross_v[cwpc_pkg::CROSS_W-1];
            has     <= 1'b1;
            state   <= tok_cl ? S_C0 : S_IDLE;
          end else begin
            state <= S_CP;
          end
        end
        S_CP: begin
          cp    <= cross_v;
          px    <= prevx;
          py    <= prevy;
          pin   <= prev_in;
          state <= S_EDGE;
        end
        S_EDGE: begin
          state <= div_start ? S_DIV : S_EMITQ;
        end
        S_DIV: begin
          if (!busy_x && !busy_y) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (slot_free) begin
            out_tok <= '{x: ix, y: iy, hv: 1'b1, cl: 1'b0};
            state   <= S_EMITQ;
          end
        end
        S_EMITQ: begin
          if (!qin || slot_free) begin
            if (qin) begin
              out_tok <= '{x: qx, y: qy, hv: 1'b1, cl: 1'b0};
            end
            if (closing) begin
              state <= S_CTOK;
            end else begin
              prevx   <= qx;
              prevy   <= qy;
              prev_in <= qin;
              state   <= tok_cl ? S_C0 : S_IDLE;
            end
          end
        end
        S_C0: begin
          closing <= 1'b1;
          if (has) begin
            qx    <= firstx;
            qy    <= firsty;
            cq    <= cross_v;
            qin   <= !cross_v[cwpc_pkg::CROSS_W-1];
            state <= S_CP;
          end else begin
            state <= S_CTOK;
          end
        end
        S_CTOK: begin
          if (slot_free) begin
            out_tok <= '{x: '0, y: '0, hv: 1'b0, cl: 1'b1};
            has     <= 1'b0;
            prev_in <= 1'b0;
            closing <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/cwpc_tail.sv]
// Output end of the chain: holds one vertex back so that the last one can carry the end mark.
module cwpc_tail (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cwpc_pkg::tok_t   in_tok,
  output logic             out_valid,
  input  logic             out_ready,
  output cwpc_pkg::coord_t out_x,
  output cwpc_pkg::coord_t out_y,
  output logic             out_last,
  output logic             out_empty
);

  logic             seen;
  cwpc_pkg::coord_t held_x, held_y;
  logic             load;

  assign in_ready = !out_valid || out_ready;

  // A word leaves when a vertex follows a held one, or when a ring close arrives.
  assign load = in_valid && in_ready && (in_tok.hv ? seen : in_tok.cl);

  // Each vertex releases the one held before it; a ring close releases the held one as last.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        if (in_tok.hv) begin
          if (seen) begin
            out_x     <= held_x;
            out_y     <= held_y;
            out_last  <= 1'b0;
            out_empty <= 1'b0;
          end
          held_x <= in_tok.x;
          held_y <= in_tok.y;
          seen   <= 1'b1;
        end else if (in_tok.cl) begin
          out_x     <= seen ? held_x : '0;
          out_y     <= seen ? held_y : '0;
          out_last  <= 1'b1;
          out_empty <= !seen;
          seen      <= 1'b0;
        end
      end
    end
  end

endmodule

[design/convex_window_polygon_clipper_core.sv]
// Sutherland-Hodgman clipper of a streamed polygon against a convex counter-clockwise window.
// The subject polygon arrives one vertex per word, its final vertex marked by tlast, and the
// clipped ring leaves in the same form; tuser marks the single all-zero word of an empty result.
// Each window edge has its own clipping cell, and the cells pass vertices down the chain, so
// several cells work on one polygon at once. A cell takes no new vertex until it is through
// with the last one and, when the edge it sees crosses the window edge, it first runs its
// shift-and-subtract intersection unit to find the crossing point.
// The window corners can be rewritten at any time the block is idle.
module convex_window_polygon_clipper_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cwpc_pkg::REG_IDX_W-1:0]      cfg_addr,
  input  logic [cwpc_pkg::COORD_BITS-1:0]     cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cwpc_pkg::DATA_W-1:0]         s_axis_tdata,  // vertex_x, vertex_y
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cwpc_pkg::DATA_W-1:0]         m_axis_tdata,  // out_x, out_y
  output logic                                m_axis_tlast,
  output logic                                m_axis_tuser   // polygon_empty
);

  cwpc_pkg::coord_t cfg_regs [cwpc_pkg::NUM_REGS];

  logic             lk_valid [cwpc_pkg::STAGES+1];
  logic             lk_ready [cwpc_pkg::STAGES+1];
  cwpc_pkg::tok_t   lk_tok   [cwpc_pkg::STAGES+1];
  cwpc_pkg::coord_t out_x, out_y;

  // Window corner registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cwpc_pkg::NUM_REGS; i++) begin
        cfg_regs[i] <= cwpc_pkg::CLIP_RESET[i];
      end
    end else if (cfg_we) begin
      cfg_regs[cfg_addr] <= cfg_data;
    end
  end

  // Input words enter the first cell as a vertex, with a ring close when marked last.
  assign lk_valid[0]   = s_axis_tvalid;
  assign s_axis_tready = lk_ready[0];
  assign lk_tok[0]     = '{x:  s_axis_tdata[cwpc_pkg::COORD_BITS-1:0],
                           y:  s_axis_tdata[2*cwpc_pkg::COORD_BITS-1:cwpc_pkg::COORD_BITS],
                           hv: 1'b1,
                           cl: s_axis_tlast};

  // Chain of clipping cells, edge e running from corner e to the next corner.
  for (genvar e = 0; e < cwpc_pkg::STAGES; e++) begin : g_cell
    localparam int B = (e + 1) % cwpc_pkg::STAGES;
    cwpc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ax        (cfg_regs[2*e]),
      .ay        (cfg_regs[2*e+1]),
      .bx        (cfg_regs[2*B]),
      .by        (cfg_regs[2*B+1]),
      .in_valid  (lk_valid[e]),
      .in_ready  (lk_ready[e]),
      .in_tok    (lk_tok[e]),
      .out_valid (lk_valid[e+1]),
      .out_ready (lk_ready[e+1]),
      .out_tok   (lk_tok[e+1])
    );
  end

  cwpc_tail u_tail (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lk_valid[cwpc_pkg::STAGES]),
    .in_ready  (lk_ready[cwpc_pkg::STAGES]),
    .in_tok    (lk_tok[cwpc_pkg::STAGES]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_last  (m_axis_tlast),
    .out_empty (m_axis_tuser)
  );

  assign m_axis_tdata = cwpc_pkg::DATA_W'({out_y, out_x});

endmodule

[design/cwpc_checker.sv]
// Port-level checks of the polygon clipper and their binding to the top level.
module cwpc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [cwpc_pkg::DATA_W-1:0] m_axis_tdata,
  input logic                        m_axis_tlast,
  input logic                        m_axis_tuser
);

  // An empty result carries zero coordinates.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("empty result with non-zero coordinates");

  // An empty result is the whole clipped polygon, so it closes it.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("empty result without end mark");

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output word offered straight after reset");

  // A stalled output word stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled output word changed");

endmodule

bind convex_window_polygon_clipper_core cwpc_checker u_cwpc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
